### hdl/bffa_pkg.sv
// Package for the bitmap first-free allocator.
// Holds field widths, request and status codes, controller states and the
// command/status structs shared by the controller and the datapath.
package bffa_pkg;

  localparam int INDEX_W  = 14;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 15;
  localparam int WORD_W   = 64;
  localparam int OFF_W    = 6;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_DOUBLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EVAL
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clr_en;      // write a cleared word during the reset sweep
    logic req_load;    // capture the request on transfer
    logic addr_load;   // point the word address at hint or released word
    logic mem_rd;      // read the addressed map word
    logic eval_en;     // commit the request from the read word
    logic addr_step;   // move to the next map word
    logic reject_load; // return an early rejection
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // sweep is at the last word
    logic reject;    // empty pool or release index beyond the pool
    logic word_full; // allocate found no free bit in the read word
    logic out_busy;  // result register still holds an untaken result
  } sts_t;

endpackage

### hdl/bffa_req_if.sv
// Request channel of the bitmap first-free allocator.
// Depends on bffa_pkg for the field widths.
interface bffa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [bffa_pkg::INDEX_W-1:0]  entry_index;

  modport source (output valid, output mode, output entry_index, input ready);
  modport sink   (input valid, input mode, input entry_index, output ready);
endinterface

### hdl/bffa_rsp_if.sv
// Result channel of the bitmap first-free allocator.
// Depends on bffa_pkg for the field widths.
interface bffa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [bffa_pkg::INDEX_W-1:0]  granted_index;
  logic [bffa_pkg::STATUS_W-1:0] status;
  logic [bffa_pkg::FREE_W-1:0]   free_left;

  modport source (output valid, output granted_index, output status, output free_left,
                  input ready);
  modport sink   (input valid, input granted_index, input status, input free_left,
                  output ready);
endinterface

### hdl/bffa_ctrl.sv
// Controller of the bitmap first-free allocator.
// Sequences the reset sweep, request capture, map word reads and commits.
// Depends on bffa_pkg for states and the command/status structs.
module bffa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  bffa_pkg::sts_t   sts,
  output bffa_pkg::cmd_t   cmd
);

  bffa_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bffa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bffa_pkg::S_CLEAR: begin
        if (sts.clr_last) state_next = bffa_pkg::S_IDLE;
      end
      bffa_pkg::S_IDLE: begin
        if (in_valid && !sts.out_busy) state_next = bffa_pkg::S_CHECK;
      end
      bffa_pkg::S_CHECK: begin
        state_next = sts.reject ? bffa_pkg::S_IDLE : bffa_pkg::S_READ;
      end
      bffa_pkg::S_READ: begin
        state_next = bffa_pkg::S_EVAL;
      end
      bffa_pkg::S_EVAL: begin
        // keep scanning upward while the word has no free bit
        state_next = sts.word_full ? bffa_pkg::S_READ : bffa_pkg::S_IDLE;
      end
      default: state_next = bffa_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bffa_pkg::S_CLEAR: begin
        cmd.clr_en = 1'b1;
      end
      bffa_pkg::S_IDLE: begin
        in_ready     = !sts.out_busy;
        cmd.req_load = in_valid && !sts.out_busy;
      end
      bffa_pkg::S_CHECK: begin
        cmd.addr_load   = 1'b1;
        cmd.reject_load = sts.reject;
      end
      bffa_pkg::S_READ: begin
        cmd.mem_rd = 1'b1;
      end
      bffa_pkg::S_EVAL: begin
        cmd.addr_step = sts.word_full;
        cmd.eval_en   = !sts.word_full;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/bffa_dp.sv
// Datapath of the bitmap first-free allocator: used-map word memory, free
// count, lowest-candidate word hint and the result register.
// Depends on bffa_pkg for widths, codes and the command/status structs.
module bffa_dp #(
  parameter int POOL_ENTRIES = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bffa_pkg::cmd_t                cmd,
  output bffa_pkg::sts_t                sts,
  input  logic                          in_mode,
  input  logic [bffa_pkg::INDEX_W-1:0]  in_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bffa_pkg::INDEX_W-1:0]  out_granted,
  output logic [bffa_pkg::STATUS_W-1:0] out_status,
  output logic [bffa_pkg::FREE_W-1:0]   out_free
);

  localparam int WORD_W    = bffa_pkg::WORD_W;
  localparam int OFF_W     = bffa_pkg::OFF_W;
  localparam int MAP_WORDS = (POOL_ENTRIES + WORD_W - 1) / WORD_W;
  localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CNT_W     = $clog2(POOL_ENTRIES + 1);
  localparam int IDX_W     = $clog2(POOL_ENTRIES);
  localparam int EXT_W     = ((IDX_W > bffa_pkg::INDEX_W) ? IDX_W : bffa_pkg::INDEX_W) + 1;
  localparam int TAIL      = POOL_ENTRIES - (MAP_WORDS - 1) * WORD_W;

  logic [WORD_W-1:0]  map_mem [MAP_WORDS];

  logic                          req_mode;
  logic [bffa_pkg::INDEX_W-1:0]  req_index;
  logic [WADDR_W-1:0]            clr_addr;
  logic [WADDR_W-1:0]            rd_addr;
  logic [WORD_W-1:0]             rd_data;
  logic [CNT_W-1:0]              free_total;
  logic [WADDR_W-1:0]            hint;

  logic [WORD_W-1:0]  tail_pad;
  logic [WORD_W-1:0]  clr_word;
  logic [EXT_W-1:0]   rel_ext;
  logic [WADDR_W-1:0] rel_word;
  logic [OFF_W-1:0]   rel_off;
  logic [OFF_W-1:0]   free_off;
  logic               rel_used;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [CNT_W-1:0]   free_next;
  logic [bffa_pkg::INDEX_W-1:0] grant_next;
  bffa_pkg::status_t  status_next;

  // Entries past the pool in the last word read as used, so a scan never grants them
  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      tail_pad[i] = (i >= TAIL);
    end
  end

  assign clr_word = (clr_addr == WADDR_W'(MAP_WORDS - 1)) ? tail_pad : '0;

  assign rel_ext  = EXT_W'(req_index);
  assign rel_word = WADDR_W'(rel_ext >> OFF_W);
  assign rel_off  = rel_ext[OFF_W-1:0];
  assign rel_used = rd_data[rel_off];

  always_comb begin
    free_off = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!rd_data[i]) free_off = OFF_W'(i);
    end
  end

  assign sts.clr_last  = (clr_addr == WADDR_W'(MAP_WORDS - 1));
  assign sts.reject    = (req_mode == bffa_pkg::MODE_ALLOC) ? (free_total == '0)
                                                            : (rel_ext >= EXT_W'(POOL_ENTRIES));
  assign sts.word_full = (req_mode == bffa_pkg::MODE_ALLOC) && (rd_data == '1);
  assign sts.out_busy  = out_valid;

  // Sweep write, or commit values for a request that reached the map word
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = rd_addr;
    wr_data     = rd_data;
    free_next   = free_total;
    grant_next  = '0;
    status_next = bffa_pkg::ST_OK;
    if (cmd.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = clr_word;
    end else if (req_mode == bffa_pkg::MODE_ALLOC) begin
      wr_en      = cmd.eval_en;
      wr_data    = rd_data | (WORD_W'(1) << free_off);
      free_next  = free_total - CNT_W'(1);
      grant_next = bffa_pkg::INDEX_W'({rd_addr, free_off});
    end else if (rel_used) begin
      wr_en     = cmd.eval_en;
      wr_data   = rd_data & ~(WORD_W'(1) << rel_off);
      free_next = free_total + CNT_W'(1);
    end else begin
      status_next = bffa_pkg::ST_DOUBLE;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (cmd.mem_rd) rd_data <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      req_mode  <= in_mode;
      req_index <= in_index;
    end
    if (cmd.addr_load) begin
      rd_addr <= (req_mode == bffa_pkg::MODE_ALLOC) ? hint : rel_word;
    end else if (cmd.addr_step) begin
      rd_addr <= rd_addr + WADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      free_total <= CNT_W'(POOL_ENTRIES);
      hint       <= '0;
    end else begin
      if (cmd.clr_en && !sts.clr_last) clr_addr <= clr_addr + WADDR_W'(1);
      if (cmd.eval_en) begin
        free_total <= free_next;
        // words below the hint are all full
        if (req_mode == bffa_pkg::MODE_ALLOC) begin
          hint <= rd_addr;
        end else if (rel_used && (rd_addr < hint)) begin
          hint <= rd_addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.eval_en || cmd.reject_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval_en) begin
      out_granted <= grant_next;
      out_status  <= status_next;
      out_free    <= bffa_pkg::FREE_W'(free_next);
    end else if (cmd.reject_load) begin
      out_granted <= '0;
      out_status  <= (req_mode == bffa_pkg::MODE_ALLOC) ? bffa_pkg::ST_FULL
                                                        : bffa_pkg::ST_DOUBLE;
      out_free    <= bffa_pkg::FREE_W'(free_total);
    end
  end

endmodule

### hdl/bitmap_first_free_allocator.sv
// Bitmap first-free allocator for a pool of POOL_ENTRIES equal entries. After
// reset the used map is swept clear, one 64-entry word a cycle, during which no
// request is taken. One request is worked at a time: it passes the check, read
// and evaluate states before its result is registered; an empty-pool allocate or
// an out-of-range release is rejected in the check state. An allocate starts at
// the lowest word that may hold a free entry and steps up over full map words;
// each step is one read of the single-port word memory. The next request is
// taken once the result has been transferred.
// Depends on bffa_pkg, bffa_req_if, bffa_rsp_if, bffa_ctrl and bffa_dp.
module bitmap_first_free_allocator #(
  parameter int POOL_ENTRIES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  bffa_req_if.sink    req,
  bffa_rsp_if.source  rsp
);

  bffa_pkg::cmd_t cmd;
  bffa_pkg::sts_t sts;

  bffa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bffa_dp #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (req.mode),
    .in_index    (req.entry_index),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_granted (rsp.granted_index),
    .out_status  (rsp.status),
    .out_free    (rsp.free_left)
  );

endmodule

### hdl/bffa_checker.sv
// Port-level checks for the bitmap first-free allocator, bound to the top level.
// Depends on bffa_pkg for field widths and status codes.
module bffa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [bffa_pkg::INDEX_W-1:0]  rsp_granted_index,
  input logic [bffa_pkg::STATUS_W-1:0] rsp_status,
  input logic [bffa_pkg::FREE_W-1:0]   rsp_free_left
);

  // a full pool always reports nothing granted and nothing left
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == bffa_pkg::ST_FULL) |->
      (rsp_granted_index == '0) && (rsp_free_left == '0))
    else $error("pool-full result with a grant or free entries left");

  a_double_no_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == bffa_pkg::ST_DOUBLE) |-> (rsp_granted_index == '0))
    else $error("rejected release carries a granted index");

  // no new request is taken while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready)
    else $error("request taken while a result is pending");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_index) &&
      $stable(rsp_status) && $stable(rsp_free_left))
    else $error("stalled result changed");

endmodule

bind bitmap_first_free_allocator bffa_checker u_bffa_checker (
  .clk               (clk),
  .rst               (rst),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_granted_index (rsp.granted_index),
  .rsp_status        (rsp.status),
  .rsp_free_left     (rsp.free_left)
);

### dv/bitmap_first_free_allocator_tb.sv
// Self-checking testbench for the bitmap first-free allocator: directed rows
// and random allocate/release traffic, scored against a predictor.
// Depends on bffa_pkg, bffa_req_if, bffa_rsp_if and bitmap_first_free_allocator.
module bitmap_first_free_allocator_tb;

  localparam int          POOL_ENTRIES = 16384;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int          DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [bffa_pkg::INDEX_W-1:0] granted_index;
    bffa_pkg::status_t            status;
    logic [bffa_pkg::FREE_W-1:0]  free_left;
  } alloc_result_t;

  typedef struct {
    logic                         mode;
    logic [bffa_pkg::INDEX_W-1:0] idx;
    bit                           known;
    alloc_result_t                want;
  } directed_row_t;

  logic clk;
  logic rst;

  bffa_req_if req_ch();
  bffa_rsp_if rsp_ch();

  bitmap_first_free_allocator #(.POOL_ENTRIES(POOL_ENTRIES)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Pool image kept by the predictor
  bit          entry_taken [POOL_ENTRIES];
  int unsigned free_cnt;
  int unsigned low_hint;     // no free entry below this index
  int unsigned top_granted;  // highest index ever handed out

  alloc_result_t pending_results[$];

  int          send_idle_pct;
  int          take_idle_pct;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned request_count;
  int unsigned grant_count;
  int unsigned full_count;
  int unsigned double_count;
  int unsigned result_count;
  logic [bffa_pkg::INDEX_W-1:0] last_released;

  directed_row_t directed_rows [21] = '{
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b1, '{14'd0, bffa_pkg::ST_OK,     15'd16383}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b1, '{14'd1, bffa_pkg::ST_OK,     15'd16382}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b1, '{14'd2, bffa_pkg::ST_OK,     15'd16381}},
    '{bffa_pkg::MODE_RELEASE, 14'd1,    1'b1, '{14'd0, bffa_pkg::ST_OK,     15'd16382}},
    '{bffa_pkg::MODE_RELEASE, 14'd1,    1'b1, '{14'd0, bffa_pkg::ST_DOUBLE, 15'd16382}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_RELEASE, 14'h3FFF, 1'b1, '{14'd0, bffa_pkg::ST_DOUBLE, 15'd16381}},
    '{bffa_pkg::MODE_RELEASE, 14'd0,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_RELEASE, 14'd0,    1'b1, '{14'd0, bffa_pkg::ST_DOUBLE, 15'd16382}},
    '{bffa_pkg::MODE_RELEASE, 14'h1FFF, 1'b1, '{14'd0, bffa_pkg::ST_DOUBLE, 15'd16382}},
    '{bffa_pkg::MODE_RELEASE, 14'h2AAA, 1'b1, '{14'd0, bffa_pkg::ST_DOUBLE, 15'd16382}},
    '{bffa_pkg::MODE_RELEASE, 14'h1555, 1'b1, '{14'd0, bffa_pkg::ST_DOUBLE, 15'd16382}},
    '{bffa_pkg::MODE_ALLOC,   14'h3FFF, 1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_ALLOC,   14'h2AAA, 1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_ALLOC,   14'h1555, 1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_RELEASE, 14'd4,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_RELEASE, 14'd2,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}},
    '{bffa_pkg::MODE_ALLOC,   14'd0,    1'b0, '{14'd0, bffa_pkg::ST_OK,     15'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // First-fit allocate or release on the pool image; one result per request
  function automatic alloc_result_t pool_step(input logic m,
                                              input logic [bffa_pkg::INDEX_W-1:0] idx);
    alloc_result_t r;
    int unsigned   probe;
    r.granted_index = '0;
    r.status        = bffa_pkg::ST_OK;
    if (m == bffa_pkg::MODE_ALLOC) begin
      if (free_cnt == 0) begin
        r.status = bffa_pkg::ST_FULL;
      end else begin
        probe = low_hint;
        while (entry_taken[probe]) probe++;
        entry_taken[probe] = 1'b1;
        free_cnt--;
        low_hint = probe + 1;
        r.granted_index = bffa_pkg::INDEX_W'(probe);
        if (probe > top_granted) top_granted = probe;
      end
    end else if (int'(idx) >= POOL_ENTRIES || !entry_taken[idx]) begin
      r.status = bffa_pkg::ST_DOUBLE;
    end else begin
      entry_taken[idx] = 1'b0;
      free_cnt++;
      if (idx < low_hint) low_hint = 32'(idx);
    end
    r.free_left = bffa_pkg::FREE_W'(free_cnt);
    return r;
  endfunction

  // Called at a rising edge; returns at the edge on which the request transfers
  task automatic send_request(input logic m, input logic [bffa_pkg::INDEX_W-1:0] idx,
                              input bit known, input alloc_result_t want);
    alloc_result_t got;
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.mode        <= m;
    req_ch.entry_index <= idx;
    do @(posedge clk); while (!req_ch.ready);
    got = pool_step(m, idx);
    pending_results = {pending_results, (known ? want : got)};
    request_count++;
    if (m == bffa_pkg::MODE_RELEASE) last_released = idx;
  endtask

  task automatic run_random(input int n, input int alloc_pct);
    logic [bffa_pkg::INDEX_W-1:0] idx;
    int                           pick;
    repeat (n) begin
      if ($urandom_range(99) < alloc_pct) begin
        // index is ignored on allocate; toggle it anyway
        send_request(bffa_pkg::MODE_ALLOC, bffa_pkg::INDEX_W'($urandom), 1'b0, '0);
      end else begin
        pick = $urandom_range(99);
        if (pick < 70)      idx = bffa_pkg::INDEX_W'($urandom_range(top_granted));
        else if (pick < 85) idx = last_released;
        else                idx = bffa_pkg::INDEX_W'($urandom);
        send_request(bffa_pkg::MODE_RELEASE, idx, 1'b0, '0);
      end
    end
  endtask

  function automatic void check_result();
    alloc_result_t want;
    bit            bad;
    result_count++;
    case (rsp_ch.status)
      bffa_pkg::ST_OK:     if (rsp_ch.granted_index != 0 || grant_count == 0) grant_count++;
      bffa_pkg::ST_FULL:   full_count++;
      bffa_pkg::ST_DOUBLE: double_count++;
      default: ;
    endcase
    if (pending_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: unexpected result index=%0d status=%0d free=%0d",
                 rsp_ch.granted_index, rsp_ch.status, rsp_ch.free_left);
      return;
    end
    want = pending_results.pop_front();
    bad  = (rsp_ch.granted_index !== want.granted_index) ||
           (rsp_ch.status !== want.status) ||
           (rsp_ch.free_left !== want.free_left);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("ERROR: #%0d index exp %0d got %0d, status exp %0d got %0d, free exp %0d got %0d",
                 result_count, want.granted_index, rsp_ch.granted_index,
                 want.status, rsp_ch.status, want.free_left, rsp_ch.free_left);
    end
  endfunction

  // Result side: random back-pressure and scoring of each transfer
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) check_result();
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst                <= 1'b1;
    req_ch.valid       <= 1'b0;
    req_ch.mode        <= bffa_pkg::MODE_ALLOC;
    req_ch.entry_index <= '0;
    mismatch_count = 0;
    request_count  = 0;
    grant_count    = 0;
    full_count     = 0;
    double_count   = 0;
    result_count   = 0;
    last_released  = '0;
    free_cnt       = POOL_ENTRIES;
    low_hint       = 0;
    top_granted    = 0;
    foreach (entry_taken[i]) entry_taken[i] = 1'b0;
    send_idle_pct  = 9;
    take_idle_pct  = 86;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_request(directed_rows[i].mode, directed_rows[i].idx,
                   directed_rows[i].known, directed_rows[i].want);
    run_random(600, 55);

    send_idle_pct = 86;
    take_idle_pct = 9;
    run_random(600, 55);

    send_idle_pct = 0;
    take_idle_pct = 0;
    // Top entry, middle entry and entry zero, then back-to-back traffic
    send_request(bffa_pkg::MODE_RELEASE, 14'h3FFF, 1'b0, '0);
    send_request(bffa_pkg::MODE_RELEASE, 14'd8192, 1'b0, '0);
    send_request(bffa_pkg::MODE_RELEASE, 14'd0, 1'b0, '0);
    send_request(bffa_pkg::MODE_ALLOC, 14'd0, 1'b0, '0);
    run_random(530, 45);
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests over %0d cycles on a %0d-entry pool, three stall mixes",
             request_count, cycle_count, POOL_ENTRIES);
    $display("Results: %0d checked, %0d pool-full, %0d rejected releases, %0d mismatches",
             result_count, full_count, double_count, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_results.size() != 0)
        $display("ERROR: %0d expected results never arrived", pending_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
